### design/cache_line_bdi_size_estimator_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the BDI size estimator
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CACHE_LINE_BDI_SIZE_ESTIMATOR_TOP_MACROS_SVH
`define CACHE_LINE_BDI_SIZE_ESTIMATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// pre holds now, so post must hold in the same cycle
`define CLBDI_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// pre holds now, so post must hold in the next cycle
`define CLBDI_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CLBDI_ASSERT_IMPL(label, pre, post, msg)
`define CLBDI_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### design/clbdi_pkg.sv
// ---------------------------------------------------------------------------
// BDI size estimator package
// Form geometry, encodings, sizes and the structs passed between modules.
// ---------------------------------------------------------------------------
package clbdi_pkg;

    localparam int FORM_COUNT = 6;
    localparam int MAX_SEGS   = 4;
    localparam int BASE_W     = 56;

    // Form order: b8d1, b4d1, b8d2, b2d1, b4d2, b8d4
    localparam int SEG_BYTES   [FORM_COUNT] = '{8, 4, 8, 2, 4, 8};
    localparam int DELTA_BYTES [FORM_COUNT] = '{1, 1, 2, 1, 2, 4};
    localparam int HIGH_BYTES  [FORM_COUNT] = '{7, 3, 6, 1, 2, 4};
    localparam int SEG_COUNT   [FORM_COUNT] = '{1, 2, 1, 4, 2, 1};

    localparam logic [6:0] FORM_SIZE [FORM_COUNT] =
        '{7'd16, 7'd20, 7'd24, 7'd34, 7'd36, 7'd40};
    localparam logic [6:0] SIZE_ZERO   = 7'd1;
    localparam logic [6:0] SIZE_REPEAT = 7'd8;
    localparam logic [6:0] SIZE_RAW    = 7'd64;

    typedef enum logic [3:0] {
        ENC_ZERO   = 4'd0,
        ENC_REPEAT = 4'd1,
        ENC_B8D1   = 4'd2,
        ENC_B4D1   = 4'd3,
        ENC_B8D2   = 4'd4,
        ENC_B2D1   = 4'd5,
        ENC_B4D2   = 4'd6,
        ENC_B8D4   = 4'd7,
        ENC_RAW    = 4'd8
    } enc_t;

    typedef logic [FORM_COUNT-1:0][BASE_W-1:0] base_array_t;

    typedef struct packed {
        logic [FORM_COUNT-1:0] captured;
        logic [FORM_COUNT-1:0] fits;
        base_array_t           base;
    } form_state_t;

    typedef struct packed {
        logic                  all_zero;
        logic                  repeat_ok;
        logic [FORM_COUNT-1:0] fits;
    } line_status_t;

endpackage

### design/clbdi_line_if.sv
// ---------------------------------------------------------------------------
// Line word channel
// Valid/ready channel carrying one 64-bit cache line word per transaction.
// ---------------------------------------------------------------------------
interface clbdi_line_if;
    logic        valid;
    logic        ready;
    logic [63:0] line_word;

    modport source (output valid, output line_word, input ready);
    modport sink   (input valid, input line_word, output ready);
endinterface

### design/clbdi_result_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying compressed size and encoding per transaction.
// ---------------------------------------------------------------------------
interface clbdi_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] compressed_bytes;
    logic [3:0] encoding;

    modport source (output valid, output compressed_bytes, output encoding, input ready);
    modport sink   (input valid, input compressed_bytes, input encoding, output ready);
endinterface

### design/clbdi_form_check.sv
// ---------------------------------------------------------------------------
// BDI form checker
// Updates base capture and fit flags of all six forms for one word.
// ---------------------------------------------------------------------------
module clbdi_form_check (
    input  logic [63:0]             word,
    input  clbdi_pkg::form_state_t  form_cur,
    output clbdi_pkg::form_state_t  form_next
);

    // Segments are walked earliest first; a base captured by one segment is
    // already in force for the later segments of the same word.
    always_comb
    begin
        logic [63:0] high;
        logic [63:0] mask;
        int          shift;
        form_next = form_cur;
        high      = '0;
        mask      = '0;
        shift     = 0;
        for (int f = 0; f < clbdi_pkg::FORM_COUNT; f++)
        begin
            mask = (64'd1 << (8 * clbdi_pkg::HIGH_BYTES[f])) - 64'd1;
            for (int k = 0; k < clbdi_pkg::MAX_SEGS; k++)
            begin
                if (k < clbdi_pkg::SEG_COUNT[f])
                begin
                    shift = 8 * (8 - clbdi_pkg::SEG_BYTES[f] * (k + 1)
                                 + clbdi_pkg::DELTA_BYTES[f]);
                    high  = (word >> shift) & mask;
                    if (high != 64'd0)
                    begin
                        if (!form_next.captured[f])
                        begin
                            form_next.captured[f] = 1'b1;
                            form_next.base[f]     = high[clbdi_pkg::BASE_W-1:0];
                        end
                        else if (high[clbdi_pkg::BASE_W-1:0] != form_next.base[f])
                        begin
                            form_next.fits[f] = 1'b0;
                        end
                    end
                end
            end
        end
    end

endmodule

### design/clbdi_line_state.sv
// ---------------------------------------------------------------------------
// BDI line state
// Holds per-line tracking state and gives the line status at each word.
// ---------------------------------------------------------------------------
module clbdi_line_state (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic [63:0]             word,
    output logic                    last,
    output clbdi_pkg::line_status_t status
);

    logic [2:0]                          pos_reg;
    logic [2:0]                          pos_next;
    logic                                zero_reg;
    logic                                zero_next;
    logic                                repeat_reg;
    logic                                repeat_next;
    logic [clbdi_pkg::FORM_COUNT-1:0]    captured_reg;
    logic [clbdi_pkg::FORM_COUNT-1:0]    captured_next;
    logic [clbdi_pkg::FORM_COUNT-1:0]    fits_reg;
    logic [clbdi_pkg::FORM_COUNT-1:0]    fits_next;
    clbdi_pkg::base_array_t              base_reg;
    logic [63:0]                         first_word_reg;
    clbdi_pkg::form_state_t              form_cur;
    clbdi_pkg::form_state_t              form_upd;
    logic                                zero_upd;
    logic                                repeat_upd;

    assign form_cur.captured = captured_reg;
    assign form_cur.fits     = fits_reg;
    assign form_cur.base     = base_reg;

    clbdi_form_check u_form_check (
        .word      (word),
        .form_cur  (form_cur),
        .form_next (form_upd)
    );

    assign last       = (pos_reg == 3'd7);
    assign zero_upd   = zero_reg & (word == 64'd0);
    assign repeat_upd = (pos_reg == 3'd0) ? 1'b1 : (repeat_reg & (word == first_word_reg));

    assign status.all_zero  = zero_upd;
    assign status.repeat_ok = repeat_upd;
    assign status.fits      = form_upd.fits;

    always_comb
    begin
        pos_next      = pos_reg;
        zero_next     = zero_reg;
        repeat_next   = repeat_reg;
        captured_next = captured_reg;
        fits_next     = fits_reg;
        if (take)
        begin
            if (last)
            begin
                pos_next      = 3'd0;
                zero_next     = 1'b1;
                repeat_next   = 1'b1;
                captured_next = '0;
                fits_next     = '1;
            end
            else
            begin
                pos_next      = pos_reg + 3'd1;
                zero_next     = zero_upd;
                repeat_next   = repeat_upd;
                captured_next = form_upd.captured;
                fits_next     = form_upd.fits;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 3'd0;
            zero_reg     <= 1'b1;
            repeat_reg   <= 1'b1;
            captured_reg <= '0;
            fits_reg     <= '1;
        end
        else
        begin
            pos_reg      <= pos_next;
            zero_reg     <= zero_next;
            repeat_reg   <= repeat_next;
            captured_reg <= captured_next;
            fits_reg     <= fits_next;
        end
    end

    // Bases are only read once captured; the first word is written at word 0.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            base_reg <= form_upd.base;
            if (pos_reg == 3'd0)
            begin
                first_word_reg <= word;
            end
        end
    end

endmodule

### design/clbdi_encoder.sv
// ---------------------------------------------------------------------------
// BDI encoding select
// Priority choice of encoding and compressed size from the line status.
// ---------------------------------------------------------------------------
module clbdi_encoder (
    input  clbdi_pkg::line_status_t status,
    output logic [6:0]              compressed_bytes,
    output logic [3:0]              encoding
);

    always_comb
    begin
        compressed_bytes = clbdi_pkg::SIZE_RAW;
        encoding         = clbdi_pkg::ENC_RAW;
        // Walk from the last form down so the earliest fitting form wins
        for (int f = clbdi_pkg::FORM_COUNT - 1; f >= 0; f--)
        begin
            if (status.fits[f])
            begin
                compressed_bytes = clbdi_pkg::FORM_SIZE[f];
                encoding         = 4'(clbdi_pkg::ENC_B8D1) + 4'(f);
            end
        end
        if (status.all_zero)
        begin
            compressed_bytes = clbdi_pkg::SIZE_ZERO;
            encoding         = clbdi_pkg::ENC_ZERO;
        end
        else if (status.repeat_ok)
        begin
            compressed_bytes = clbdi_pkg::SIZE_REPEAT;
            encoding         = clbdi_pkg::ENC_REPEAT;
        end
    end

endmodule

### design/cache_line_bdi_size_estimator_top.sv
// ---------------------------------------------------------------------------
// Cache line BDI size estimator
// Estimates the base-delta-immediate compressed size of a 64-byte line.
// ---------------------------------------------------------------------------
//
//   channel      dir  payload                          per transaction
//   line_words   in   line_word[63:0]                  one line word
//   results      out  compressed_bytes[6:0], enc[3:0]  one per eight words
//
// One word is taken every cycle unless stalled; a line costs eight
// input transactions. A word is held in the input register, then the line
// state is updated and, on the eighth word, the result register is loaded.
// Reset clears the input and result valids and returns to word 0.
// A pending result stalls only the eighth word of the next line; words
// 0 to 6 keep flowing while the result waits.
//
`include "cache_line_bdi_size_estimator_top_macros.svh"

module cache_line_bdi_size_estimator_top (
    input  logic           clk,
    input  logic           rst_n,
    clbdi_line_if.sink     line_words,
    clbdi_result_if.source results
);

    // Input register stage
    logic        stage_valid_reg;
    logic        stage_valid_next;
    logic [63:0] stage_word_reg;

    // Result register stage
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [6:0]  out_size_reg;
    logic [3:0]  out_enc_reg;

    logic                    advance;
    logic                    out_load;
    logic                    line_last;
    clbdi_pkg::line_status_t line_status;
    logic [6:0]              enc_size;
    logic [3:0]              enc_code;

    // A word leaves the input register unless it closes a line and the
    // result register still holds an untaken result.
    assign advance  = stage_valid_reg & (~line_last | ~out_valid_reg | results.ready);
    assign out_load = advance & line_last;

    assign line_words.ready = ~stage_valid_reg | advance;

    clbdi_line_state u_line_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (advance),
        .word   (stage_word_reg),
        .last   (line_last),
        .status (line_status)
    );

    clbdi_encoder u_encoder (
        .status           (line_status),
        .compressed_bytes (enc_size),
        .encoding         (enc_code)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (line_words.ready)
        begin
            stage_valid_next = line_words.valid;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_words.valid && line_words.ready)
        begin
            stage_word_reg <= line_words.line_word;
        end
        if (out_load)
        begin
            out_size_reg <= enc_size;
            out_enc_reg  <= enc_code;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.compressed_bytes = out_size_reg;
    assign results.encoding         = out_enc_reg;

    // A held word must not change under a stall
    `CLBDI_ASSERT_NEXT(a_stage_hold, stage_valid_reg && !advance, stage_valid_reg && $stable(stage_word_reg), "input word changed while stalled")
    // A line end must never overwrite an untaken result
    `CLBDI_ASSERT_IMPL(a_no_overwrite, out_valid_reg && !results.ready && stage_valid_reg && line_last, !advance, "pending result overwritten")
    // Zero encoding always carries the one-byte size
    `CLBDI_ASSERT_IMPL(a_zero_size, out_valid_reg && out_enc_reg == clbdi_pkg::ENC_ZERO, out_size_reg == clbdi_pkg::SIZE_ZERO, "zero encoding with wrong size")

endmodule

### tb/cache_line_bdi_size_estimator_top_tb.sv
// ---------------------------------------------------------------------------
// BDI size estimator testbench
// Feeds whole cache lines as eight word transactions and predicts the
// compressed size and encoding of each line. Every result transaction is
// checked against the oldest prediction. Both channels idle in random bursts,
// and the result side at one point holds off long enough to back up the input.
// ---------------------------------------------------------------------------
module cache_line_bdi_size_estimator_top_tb;

    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 8;      // input reg + line update + result reg, with margin
    localparam int LONG_HOLD     = 300;    // cycles of result back-pressure
    localparam int RUN_LIMIT     = 4000000;
    localparam int PRINT_CAP     = 40;

    // Kinds of generated line
    typedef enum int {
        LK_ZERO,
        LK_REPEAT,
        LK_FORM,
        LK_NEAR_MISS,
        LK_SPARSE,
        LK_NOISE
    } line_kind_t;

    // -----------------------------------------------------------------------
    // Scoreboard: folds accepted words into a running line state and queues
    // one expected size/encoding per completed line.
    // -----------------------------------------------------------------------
    class line_size_scoreboard;
        typedef struct {
            logic [6:0]      size;
            clbdi_pkg::enc_t enc;
        } line_size_t;

        line_size_t  expected_sizes[$];
        int unsigned errors;
        int unsigned words_taken;
        int unsigned lines_checked;
        int unsigned enc_seen[clbdi_pkg::ENC_RAW+1];

        int unsigned                      word_idx;
        bit                               all_zero;
        bit                               same_word;
        logic [63:0]                      word0;
        bit [clbdi_pkg::FORM_COUNT-1:0]   captured;
        bit [clbdi_pkg::FORM_COUNT-1:0]   fits;
        logic [clbdi_pkg::BASE_W-1:0]     base_hi[clbdi_pkg::FORM_COUNT];

        function new();
            restart_line();
        endfunction

        function void restart_line();
            word_idx  = 0;
            all_zero  = 1'b1;
            same_word = 1'b1;
            word0     = '0;
            captured  = '0;
            fits      = '1;
            foreach (base_hi[f])
                base_hi[f] = '0;
        endfunction

        function int unsigned pending();
            return expected_sizes.size();
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP)
                $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void take_word(logic [63:0] w);
            int          shift;
            logic [63:0] mask;
            logic [63:0] hi;
            line_size_t  exp;

            words_taken++;
            if (w != '0)
                all_zero = 1'b0;
            if (word_idx == 0)
                word0 = w;
            else if (w != word0)
                same_word = 1'b0;

            // High bytes compared as one masked value; first nonzero segment becomes the base
            for (int f = 0; f < clbdi_pkg::FORM_COUNT; f++)
            begin
                mask = (64'd1 << (8 * clbdi_pkg::HIGH_BYTES[f])) - 64'd1;
                for (int k = 0; k < 8 / clbdi_pkg::SEG_BYTES[f]; k++)
                begin
                    shift = 8 * (8 - clbdi_pkg::SEG_BYTES[f] * (k + 1)
                                 + clbdi_pkg::DELTA_BYTES[f]);
                    hi = (w >> shift) & mask;
                    if (hi != '0)
                    begin
                        if (!captured[f])
                        begin
                            captured[f] = 1'b1;
                            base_hi[f]  = hi[clbdi_pkg::BASE_W-1:0];
                        end
                        else if (hi[clbdi_pkg::BASE_W-1:0] != base_hi[f])
                        begin
                            fits[f] = 1'b0;
                        end
                    end
                end
            end

            if (word_idx < 7)
            begin
                word_idx++;
                return;
            end

            if (all_zero)
            begin
                exp.size = clbdi_pkg::SIZE_ZERO;
                exp.enc  = clbdi_pkg::ENC_ZERO;
            end
            else if (same_word)
            begin
                exp.size = clbdi_pkg::SIZE_REPEAT;
                exp.enc  = clbdi_pkg::ENC_REPEAT;
            end
            else
            begin
                exp.size = clbdi_pkg::SIZE_RAW;
                exp.enc  = clbdi_pkg::ENC_RAW;
                // walk downwards so the lowest fitting form wins
                for (int f = clbdi_pkg::FORM_COUNT - 1; f >= 0; f--)
                begin
                    if (fits[f])
                    begin
                        exp.size = clbdi_pkg::FORM_SIZE[f];
                        exp.enc  = clbdi_pkg::enc_t'(int'(clbdi_pkg::ENC_B8D1) + f);
                    end
                end
            end
            expected_sizes.insert(expected_sizes.size(), exp);
            restart_line();
        endfunction

        task check_size(logic [6:0] got_size, logic [3:0] got_enc);
            line_size_t exp;

            if (expected_sizes.size() == 0)
            begin
                report($sformatf("result size=%0d enc=%0d with no line pending",
                                 got_size, got_enc));
                return;
            end
            exp = expected_sizes.pop_front();
            lines_checked++;
            if (got_size !== exp.size)
                report($sformatf("line %0d compressed_bytes got %0d want %0d",
                                 lines_checked, got_size, exp.size));
            if (got_enc !== exp.enc)
                report($sformatf("line %0d encoding got %0d want %s",
                                 lines_checked, got_enc, exp.enc.name()));
            else
                enc_seen[exp.enc]++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    clbdi_line_if   line_ch();
    clbdi_result_if result_ch();

    cache_line_bdi_size_estimator_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_words (line_ch),
        .results    (result_ch)
    );

    line_size_scoreboard sb = new();

    // Idle rates in percent per word / per cycle; changed between phases
    int unsigned send_idle_pct;
    int unsigned rcv_idle_pct;
    bit          long_hold_req;

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // -----------------------------------------------------------------------
    // Monitors: both channels sampled at the rising edge. A word and a result
    // may land on the same edge; the result always belongs to an older line,
    // so the queue order is unaffected.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && line_ch.valid && line_ch.ready)
            sb.take_word(line_ch.line_word);
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_size(result_ch.compressed_bytes, result_ch.encoding);
    end

    // -----------------------------------------------------------------------
    // Result side. Ready changes at the falling edge only. A long hold-off is
    // requested by the stimulus and counted out here, while the sender keeps
    // offering words so the block backs up and stalls its input.
    // -----------------------------------------------------------------------
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if ($urandom_range(0, 99) < rcv_idle_pct)
            begin
                // burst of stalled cycles
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Build one line of the given kind; form picks the base-delta geometry
    function automatic void make_line(input line_kind_t kind, input int form,
                                      output logic [63:0] words[8]);
        int          s;
        int          d;
        int          lo;
        int          w;
        int          k;
        logic [63:0] hi_mask;
        logic [63:0] d_mask;
        logic [63:0] base;
        logic [63:0] seg_hi;
        logic [63:0] rep;

        case (kind)
            LK_ZERO:
            begin
                foreach (words[i])
                    words[i] = '0;
            end
            LK_REPEAT:
            begin
                case ($urandom_range(0, 3))
                    0:       rep = '1;
                    1:       rep = 64'($urandom_range(1, 255));
                    default: rep = rand64();
                endcase
                if (rep == '0)
                    rep = 64'd1;
                foreach (words[i])
                    words[i] = rep;
            end
            LK_FORM, LK_NEAR_MISS:
            begin
                s = clbdi_pkg::SEG_BYTES[form];
                d = clbdi_pkg::DELTA_BYTES[form];
                hi_mask = (64'd1 << (8 * (s - d))) - 64'd1;
                d_mask  = (64'd1 << (8 * d)) - 64'd1;
                if ($urandom_range(0, 2) == 0)
                    base = 64'($urandom_range(1, 255));
                else
                    base = rand64() & hi_mask;
                if (base == '0)
                    base = hi_mask;
                foreach (words[i])
                begin
                    words[i] = '0;
                    for (int j = 0; j < 8 / s; j++)
                    begin
                        lo = 8 * (8 - s * (j + 1));
                        seg_hi = ($urandom_range(0, 3) == 0) ? 64'd0 : base;
                        words[i] |= (seg_hi << (lo + 8 * d)) | ((rand64() & d_mask) << lo);
                    end
                end
                if (kind == LK_NEAR_MISS)
                begin
                    // flip one bit in the high bytes of one segment
                    w  = $urandom_range(0, 7);
                    k  = $urandom_range(0, 8 / s - 1);
                    lo = 8 * (8 - s * (k + 1)) + 8 * d;
                    words[w] ^= 64'd1 << (lo + $urandom_range(0, 8 * (s - d) - 1));
                end
            end
            LK_SPARSE:
            begin
                foreach (words[i])
                begin
                    words[i] = '0;
                    for (int b = 0; b < 8; b++)
                        if ($urandom_range(0, 3) == 0)
                            words[i][8*b +: 8] = 8'($urandom);
                end
            end
            default:
            begin
                foreach (words[i])
                    words[i] = rand64();
            end
        endcase
    endfunction

    // Offer one word at the falling edge and hold it until a transaction
    task automatic send_word(input logic [63:0] w);
        @(negedge clk);
        line_ch.valid     <= 1'b1;
        line_ch.line_word <= w;
        do
            @(posedge clk);
        while (!line_ch.ready);
    endtask

    // Eight words, with a random idle burst possible ahead of any of them
    task automatic send_line(input logic [63:0] words[8]);
        int n;
        foreach (words[i])
        begin
            if ($urandom_range(0, 99) < send_idle_pct)
            begin
                n = $urandom_range(1, 6);
                @(negedge clk);
                line_ch.valid <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            send_word(words[i]);
        end
    endtask

    task automatic send_random_lines(input int count);
        logic [63:0] words[8];
        int          r;
        line_kind_t  kind;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)       kind = LK_ZERO;
            else if (r < 12) kind = LK_REPEAT;
            else if (r < 62) kind = LK_FORM;
            else if (r < 80) kind = LK_NEAR_MISS;
            else if (r < 90) kind = LK_SPARSE;
            else             kind = LK_NOISE;
            make_line(kind, $urandom_range(0, clbdi_pkg::FORM_COUNT - 1), words);
            send_line(words);
        end
    endtask

    // Sender goes quiet until every expected result has arrived
    task automatic wait_results_drained();
        @(negedge clk);
        line_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        logic [63:0] words[8];

        rst_n             = 1'b0;
        line_ch.valid     = 1'b0;
        line_ch.line_word = '0;
        long_hold_req     = 1'b0;
        send_idle_pct     = 0;
        rcv_idle_pct      = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: all-zero line, all-ones repeat, a line whose high bytes
        // are zero everywhere (no base, b8d1 still fits), and an
        // alternating pattern that fits no form.
        make_line(LK_ZERO, 0, words);
        send_line(words);
        foreach (words[i])
            words[i] = '1;
        send_line(words);
        foreach (words[i])
            words[i] = 64'($urandom_range(0, 255)) | 64'(i + 1);
        send_line(words);
        foreach (words[i])
            words[i] = (i % 2) ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA;
        send_line(words);
        wait_results_drained();

        // Random lines, idling on both sides
        send_idle_pct = 15;
        rcv_idle_pct  = 15;
        send_random_lines(70);

        // Long result hold-off while the sender keeps pushing lines
        long_hold_req = 1'b1;
        send_random_lines(6);
        wait_results_drained();

        // Sender-side gaps only, then result-side stalls only
        send_idle_pct = 30;
        rcv_idle_pct  = 0;
        send_random_lines(25);
        send_idle_pct = 0;
        rcv_idle_pct  = 40;
        send_random_lines(25);

        // Closing stretch at full rate
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        send_random_lines(32);

        wait_results_drained();

        $display("covered %0d lines (%0d word transactions), incl. long back-pressure",
                 sb.lines_checked, sb.words_taken);
        $display("encodings zero/rep/b8d1/b4d1/b8d2/b2d1/b4d2/b8d4/raw: %0d %0d %0d %0d %0d",
                 sb.enc_seen[clbdi_pkg::ENC_ZERO], sb.enc_seen[clbdi_pkg::ENC_REPEAT],
                 sb.enc_seen[clbdi_pkg::ENC_B8D1], sb.enc_seen[clbdi_pkg::ENC_B4D1],
                 sb.enc_seen[clbdi_pkg::ENC_B8D2],
                 " %0d %0d %0d %0d",
                 sb.enc_seen[clbdi_pkg::ENC_B2D1], sb.enc_seen[clbdi_pkg::ENC_B4D2],
                 sb.enc_seen[clbdi_pkg::ENC_B8D4], sb.enc_seen[clbdi_pkg::ENC_RAW]);
        if (sb.errors == 0)
            $display("[cache_line_bdi_size_estimator_top] OK");
        else
            $display("[cache_line_bdi_size_estimator_top] ERROR");
        $finish;
    end

    // Watchdog: a hung handshake or a missing result ends here
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("[cache_line_bdi_size_estimator_top] ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/clbdi_pkg.sv
design/clbdi_line_if.sv
design/clbdi_result_if.sv
design/clbdi_form_check.sv
design/clbdi_line_state.sv
design/clbdi_encoder.sv
design/cache_line_bdi_size_estimator_top.sv
tb/cache_line_bdi_size_estimator_top_tb.sv
